/* sv/ted_pkg.sv */
// shared types, constants and encodings for the text decoder
`timescale 1ns / 1ps

package ted_pkg;

    localparam int LOOKAHEAD_BYTES_DEF = 16;
    localparam int CHECK_WINDOW        = 16;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    // encoding_mode register values
    localparam logic [1:0] ENC_LE      = 2'd0;
    localparam logic [1:0] ENC_UTF8    = 2'd1;
    localparam logic [1:0] ENC_BE      = 2'd2;
    localparam logic [1:0] MODE_DETECT = 2'd3;

    // register index taken from paddr[2]
    localparam logic REG_IDX_MODE = 1'b0;

    localparam logic [7:0] BOM8_0   = 8'hEF;
    localparam logic [7:0] BOM8_1   = 8'hBB;
    localparam logic [7:0] BOM8_2   = 8'hBF;
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_FE  = 8'hFE;
    localparam logic [7:0] MASK_2B  = 8'h1F;
    localparam logic [7:0] MASK_3B  = 8'h0F;
    localparam logic [7:0] LEAD_1B  = 8'h80;
    localparam logic [7:0] LEAD_2B  = 8'hC0;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] LEAD_4B  = 8'hF0;
    localparam logic [7:0] LEAD_BAD = 8'hF8;

    localparam logic [15:0] UNIT_UNDERSCORE = 16'h005F;
    localparam logic [15:0] SURR_BELOW      = 16'hD7FF;
    localparam logic [15:0] SURR_ABOVE      = 16'hE000;

    // utf-8 sequence kinds
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THR  = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_READ,
        ST_DECODE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic acc_in;      // input request taken
        logic resolve;     // pick encoding and skip from lookahead
        logic rd_issue;    // read lookahead at replay pointer
        logic sel_rd;      // decoder input from lookahead read data
        logic dec_replay;  // commit decode of replayed byte
        logic flush;       // release held result and end replay
    } t_cmd;

    typedef struct packed {
        logic detecting;
        logic det_fire;
        logic skip_empty;
        logic ptr_end;
        logic rd_emit;
        logic hold_valid;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        logic [8:0]  held;
        logic [1:0]  pend;
        logic [1:0]  kind;
        logic [15:0] partial;
    } t_dec;

endpackage

/* sv/text_encoding_detect_utf8_decode.sv */
// Result: outside detect mode, a decoded byte shows its result in the cycle after the request is taken.
// Throughput: one byte per cycle once the encoding is known, bounded by the output register.
// Detect mode: up to LOOKAHEAD_BYTES bytes are buffered at one per cycle, then a resolve step,
//   then a lookahead memory read and a decode for each replayed byte, then a flush.
// Reset: synchronous, active low; mode returns to auto-detect, no memory clearing pass.
`timescale 1ns / 1ps

module text_encoding_detect_utf8_decode
    import ted_pkg::*;
#(
    parameter int LOOKAHEAD_BYTES = LOOKAHEAD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_code_unit,
    output logic [1:0]        o_resolved_encoding,
    output logic              o_run_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cmd       cmd;
    t_sts       sts;
    logic       cfg_wr;
    logic [1:0] mode;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MODE);
    assign prdata = (paddr[2] == REG_IDX_MODE) ? {{(DATA_W - 2){1'b0}}, mode} : '0;

    ted_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ted_dp #(
        .LOOKAHEAD_BYTES (LOOKAHEAD_BYTES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .i_cfg_wr            (cfg_wr),
        .i_cfg_mode          (pwdata[1:0]),
        .o_mode              (mode),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_code_unit         (o_code_unit),
        .o_resolved_encoding (o_resolved_encoding),
        .o_run_last          (o_run_last)
    );

endmodule

/* sv/ted_ctrl.sv */
// sequencing of lookahead resolve, replay and flush
`timescale 1ns / 1ps

module ted_ctrl
    import ted_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = i_sts.detecting || i_sts.out_free;
                o_cmd.acc_in = i_valid && o_ready;
                if (o_cmd.acc_in && i_sts.detecting && i_sts.det_fire) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state = i_sts.skip_empty ? ST_FLUSH : ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_DECODE;
            end
            ST_DECODE: begin
                o_cmd.sel_rd = 1'b1;
                // a second result needs the output slot for the held one
                if (!(i_sts.rd_emit && i_sts.hold_valid && !i_sts.out_free)) begin
                    o_cmd.dec_replay = 1'b1;
                    n_state = i_sts.ptr_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!(i_sts.hold_valid && !i_sts.out_free)) begin
                    o_cmd.flush = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/ted_dp.sv */
// lookahead memory, detection flags, byte decoder and output register
`timescale 1ns / 1ps

module ted_dp
    import ted_pkg::*;
#(
    parameter int LOOKAHEAD_BYTES = LOOKAHEAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_wr,
    input  logic [1:0]  i_cfg_mode,
    output logic [1:0]  o_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic [1:0]  o_resolved_encoding,
    output logic        o_run_last
);

    localparam int AW = $clog2(LOOKAHEAD_BYTES);
    localparam int CW = $clog2(LOOKAHEAD_BYTES + 1);

    function automatic t_dec decode(input logic [1:0] enc, input logic [8:0] held,
                                    input logic [1:0] pend, input logic [1:0] kind,
                                    input logic [15:0] partial, input logic [7:0] b);
        t_dec d;
        d.emit    = 1'b0;
        d.unit    = '0;
        d.held    = held;
        d.pend    = pend;
        d.kind    = kind;
        d.partial = partial;
        if (enc == ENC_LE || enc == ENC_BE) begin
            if (held[8]) begin
                d.emit = 1'b1;
                d.unit = (enc == ENC_LE) ? {b, held[7:0]} : {held[7:0], b};
                d.held = '0;
            end else begin
                d.held = {1'b1, b};
            end
        end else if (pend == 2'd0) begin
            if (b < LEAD_1B) begin
                d.emit = 1'b1;
                d.unit = {8'd0, b};
            end else if (b < LEAD_2B) begin
                d.pend = 2'd0;
            end else if (b < LEAD_3B) begin
                d.partial = {8'd0, b & MASK_2B};
                d.pend    = 2'd1;
                d.kind    = SEQ_TWO;
            end else if (b < LEAD_4B) begin
                d.partial = {8'd0, b & MASK_3B};
                d.pend    = 2'd2;
                d.kind    = SEQ_THR;
            end else if (b < LEAD_BAD) begin
                d.partial = '0;
                d.pend    = 2'd3;
                d.kind    = SEQ_FOUR;
            end
        end else begin
            if (kind != SEQ_FOUR) begin
                d.partial = {partial[9:0], b[5:0]};
            end
            d.pend = pend - 2'd1;
            if (d.pend == 2'd0) begin
                if (kind == SEQ_FOUR) begin
                    d.emit = 1'b1;
                    d.unit = UNIT_UNDERSCORE;
                end else if (d.partial <= SURR_BELOW || d.partial >= SURR_ABOVE) begin
                    d.emit = 1'b1;
                    d.unit = d.partial;
                end
                d.kind    = SEQ_NONE;
                d.partial = '0;
            end
        end
        return d;
    endfunction

    logic [7:0]  r_mem [LOOKAHEAD_BYTES];
    logic [7:0]  r_rd_data;
    logic [1:0]  r_mode;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic        r_detecting;
    logic        r_last_seen;
    logic        r_le_ok;
    logic        r_be_ok;
    logic        r_even_nz;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [1:0]  r_enc;
    logic [8:0]  r_held;
    logic [1:0]  r_pend;
    logic [1:0]  r_kind;
    logic [15:0] r_partial;
    logic        r_hold_valid;
    logic [15:0] r_hold_unit;
    logic        r_out_valid;
    logic [15:0] r_out_unit;
    logic [1:0]  r_out_enc;
    logic        r_out_last;

    t_dec        n_dec;
    logic [7:0]  dec_byte;
    logic        out_free;
    logic        acc_det;
    logic        acc_run;
    logic        do_restart;
    logic [1:0]  rs_mode;
    logic [1:0]  res_enc;
    logic [1:0]  res_skip;

    assign dec_byte = i_cmd.sel_rd ? r_rd_data : i_data_byte;
    assign n_dec    = decode(r_enc, r_held, r_pend, r_kind, r_partial, dec_byte);
    assign out_free = !r_out_valid || i_ready;
    assign acc_det  = i_cmd.acc_in && r_detecting;
    assign acc_run  = i_cmd.acc_in && !r_detecting;

    assign do_restart = !i_rst_n || i_cfg_wr || (acc_run && i_last_byte)
                        || (i_cmd.flush && r_last_seen);
    assign rs_mode    = !i_rst_n ? MODE_DETECT : (i_cfg_wr ? i_cfg_mode : r_mode);

    // bom first, then zero-byte pattern over complete pairs
    always_comb begin
        res_skip = 2'd0;
        if (r_count >= CW'(3) && r_b0 == BOM8_0 && r_b1 == BOM8_1 && r_b2 == BOM8_2) begin
            res_enc  = ENC_UTF8;
            res_skip = 2'd3;
        end else if (r_count >= CW'(2) && r_b0 == BYTE_FF && r_b1 == BYTE_FE) begin
            res_enc  = ENC_LE;
            res_skip = 2'd2;
        end else if (r_count >= CW'(2) && r_b0 == BYTE_FE && r_b1 == BYTE_FF) begin
            res_enc  = ENC_BE;
            res_skip = 2'd2;
        end else if (!r_le_ok && !r_be_ok) begin
            res_enc = ENC_UTF8;
        end else if (!r_le_ok) begin
            res_enc = ENC_BE;
        end else begin
            res_enc = ENC_LE;
        end
    end

    always_comb begin
        o_sts.detecting  = r_detecting;
        o_sts.det_fire   = (r_count == CW'(LOOKAHEAD_BYTES - 1)) || i_last_byte;
        o_sts.skip_empty = CW'(res_skip) >= r_count;
        o_sts.ptr_end    = CW'(r_ptr + 1'b1) == r_count;
        o_sts.rd_emit    = n_dec.emit;
        o_sts.hold_valid = r_hold_valid;
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (acc_det) begin
            r_mem[r_count[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DETECT;
        end else if (i_cfg_wr) begin
            r_mode <= i_cfg_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_restart) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_detecting <= (rs_mode == MODE_DETECT);
            r_enc       <= (rs_mode == MODE_DETECT) ? ENC_LE : rs_mode;
            r_last_seen <= 1'b0;
            r_le_ok     <= 1'b1;
            r_be_ok     <= 1'b1;
            r_even_nz   <= 1'b0;
            r_held      <= '0;
            r_pend      <= '0;
            r_kind      <= SEQ_NONE;
            r_partial   <= '0;
        end else begin
            if (acc_det) begin
                r_count     <= r_count + 1'b1;
                r_last_seen <= i_last_byte;
                if (32'(r_count) < CHECK_WINDOW) begin
                    if (!r_count[0]) begin
                        r_even_nz <= (i_data_byte != 8'd0);
                    end else begin
                        r_be_ok <= r_be_ok && !r_even_nz;
                        r_le_ok <= r_le_ok && (i_data_byte == 8'd0);
                    end
                end
                if (r_count == CW'(0)) begin
                    r_b0 <= i_data_byte;
                end
                if (r_count == CW'(1)) begin
                    r_b1 <= i_data_byte;
                end
                if (r_count == CW'(2)) begin
                    r_b2 <= i_data_byte;
                end
            end
            if (acc_run || i_cmd.dec_replay) begin
                r_held    <= n_dec.held;
                r_pend    <= n_dec.pend;
                r_kind    <= n_dec.kind;
                r_partial <= n_dec.partial;
            end
            if (i_cmd.resolve) begin
                r_enc <= res_enc;
                r_ptr <= CW'(res_skip);
            end
            if (i_cmd.dec_replay) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.flush) begin
                r_detecting <= 1'b0;
                r_count     <= '0;
            end
        end
    end

    // newest replay result waits here until it is known whether it ends the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.dec_replay && n_dec.emit) begin
            r_hold_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_hold_valid <= 1'b0;
        end
        if (i_cmd.dec_replay && n_dec.emit) begin
            r_hold_unit <= n_dec.unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_run && n_dec.emit) begin
            r_out_valid <= 1'b1;
            r_out_unit  <= n_dec.unit;
            r_out_enc   <= r_enc;
            r_out_last  <= 1'b1;
        end else if (i_cmd.dec_replay && n_dec.emit && r_hold_valid) begin
            r_out_valid <= 1'b1;
            r_out_unit  <= r_hold_unit;
            r_out_enc   <= r_enc;
            r_out_last  <= 1'b0;
        end else if (i_cmd.flush && r_hold_valid) begin
            r_out_valid <= 1'b1;
            r_out_unit  <= r_hold_unit;
            r_out_enc   <= r_enc;
            r_out_last  <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_mode              = r_mode;
    assign o_valid             = r_out_valid;
    assign o_code_unit         = r_out_unit;
    assign o_resolved_encoding = r_out_enc;
    assign o_run_last          = r_out_last;

endmodule
